/* rtl/s2da_pkg.sv */
// Shared constants, types and helpers for the signed binary to decimal ASCII converter.
package s2da_pkg;

  // Default operand width
  localparam int DATA_WIDTH_DEF = 32;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Control from the sequencer to the double-dabble unit
  typedef struct packed {
    logic load;  // take a new magnitude, clear the BCD register
    logic step;  // one shift-and-add-3 step
  } s2da_ctrl_t;

  // Number of decimal digits of the largest magnitude, 2^(width-1)
  function automatic int dec_digits(input int width);
    logic [63:0] p;
    int          n;
    p = 64'd1 << (width - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (p != 64'd0) begin
        p = p / 64'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

/* rtl/s2da_dabble.sv */
// Double-dabble unit: shifts one magnitude bit per step into a packed BCD register.
module s2da_dabble import s2da_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int NUM_DIGITS = dec_digits(DATA_WIDTH)
) (
  input  logic                      clk,
  input  s2da_ctrl_t                ctrl,
  input  logic [DATA_WIDTH-1:0]     mag,
  output logic [4*NUM_DIGITS-1:0]   bcd
);

  localparam int BCD_W = 4 * NUM_DIGITS;

  logic [DATA_WIDTH-1:0] bin;
  logic [BCD_W-1:0]      bcd_adj;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  // Load, or shift the binary MSB into the adjusted BCD word
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= mag;
      bcd <= '0;
    end else if (ctrl.step) begin
      bin <= {bin[DATA_WIDTH-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[DATA_WIDTH-1]};
    end
  end

endmodule

/* rtl/signed_int_to_decimal_ascii_core.sv */
// Top level: sequencer, sign handling and character output register.
// Sequence: after accept, one double-dabble step per magnitude bit, then a skip of leading zero
// digits (at most NUM_DIGITS-1), a minus sign for a negative item, then the digit characters.
// Not pipelined: a new item is accepted only once the last character of the previous one has
// been pushed into the output register; the bit-serial double-dabble loop dominates the time.
// Reset: synchronous, active high; returns to idle with no character pending.
module signed_int_to_decimal_ascii_core import s2da_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            character,
  output logic                  last
);

  localparam int NUM_DIGITS = dec_digits(DATA_WIDTH);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SKIP  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic                  neg, neg_next;
  logic                  out_valid_next;
  logic [7:0]            character_next;
  logic                  last_next;
  logic                  in_fire;
  logic                  slot_free;
  logic                  push;
  logic [DATA_WIDTH-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [3:0]            digit;
  s2da_ctrl_t            ctrl;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // Two's-complement magnitude; the most negative value maps to 2^(W-1) unsigned
  assign mag = value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;

  assign digit = bcd[{idx, 2'b00} +: 4];

  s2da_dabble #(
    .DATA_WIDTH (DATA_WIDTH),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk  (clk),
    .ctrl (ctrl),
    .mag  (mag),
    .bcd  (bcd)
  );

  // Sequence conversion, leading-zero skip and character emission
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    idx_next       = idx;
    neg_next       = neg;
    ctrl.load      = 1'b0;
    ctrl.step      = 1'b0;
    push           = 1'b0;
    character_next = character;
    last_next      = last;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctrl.load  = 1'b1;
          neg_next   = value[DATA_WIDTH-1];
          cnt_next   = CNT_W'(DATA_WIDTH);
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.step = 1'b1;
        cnt_next  = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          idx_next   = IDX_W'(NUM_DIGITS - 1);
          state_next = S_SKIP;
        end
      end
      S_SKIP: begin
        if (digit == 4'd0 && idx != '0) begin
          idx_next = idx - IDX_W'(1);
        end else if (neg) begin
          state_next = S_SIGN;
        end else begin
          state_next = S_DIGIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          push           = 1'b1;
          character_next = CHAR_MINUS;
          last_next      = 1'b0;
          state_next     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          push           = 1'b1;
          character_next = CHAR_ZERO + {4'd0, digit};
          last_next      = (idx == '0);
          if (idx == '0) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx - IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold a character until taken, drop valid when taken with nothing new
  always_comb begin
    if (push) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    idx       <= idx_next;
    neg       <= neg_next;
    character <= character_next;
    last      <= last_next;
  end

  // An accepted item starts conversion and closes the input
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_CONV) && !in_ready)
    else $error("accepted item did not start conversion");

  // The conversion counter never runs out while converting
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> (cnt != '0))
    else $error("conversion counter underflow");

  // A minus sign is sent only for a negative item
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SIGN) |-> neg)
    else $error("sign emitted for non-negative item");

  // Every pushed digit character is a decimal digit
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGIT) |-> (digit <= 4'd9))
    else $error("BCD digit out of range");

endmodule
